// ----- hw/rtl/qlt_pkg.sv -----
// Shared types, character constants and helper functions for the quoted line tokenizer.
package qlt_pkg;

    localparam int unsigned FifoDepth = 8;
    localparam int unsigned MaxPush   = 3;

    localparam logic [1:0] KIND_CHAR      = 2'd0;
    localparam logic [1:0] KIND_TOKEN_END = 2'd1;
    localparam logic [1:0] KIND_LINE_END  = 2'd2;

    localparam logic [1:0] MODE_SKIP        = 2'd0;
    localparam logic [1:0] MODE_TOKEN       = 2'd1;
    localparam logic [1:0] MODE_AFTER_QUOTE = 2'd2;
    localparam logic [1:0] MODE_COMMENT     = 2'd3;

    localparam logic [1:0] Q_NONE   = 2'd0;
    localparam logic [1:0] Q_DOUBLE = 2'd1;
    localparam logic [1:0] Q_SINGLE = 2'd2;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic ACTION_CHAR = 1'b0;
    localparam logic ACTION_EOL  = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_char;
        logic       last;
    } result_t;

    // Group of results produced by one decoded request
    typedef struct packed {
        logic [1:0]  num;
        result_t [2:0] item;
    } push_t;

    function automatic logic is_space(input logic [7:0] c);
        logic r;
        r = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        return r;
    endfunction

    function automatic logic is_escapable(input logic [7:0] c);
        logic r;
        r = is_space(c) || (c == CH_DQUOTE) || (c == CH_SQUOTE) ||
            (c == CH_BSLASH) || (c == CH_HASH);
        return r;
    endfunction

endpackage

// ----- hw/rtl/qlt_in_if.sv -----
// Input channel carrying one line byte or an end-of-line request.
interface qlt_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] char_code;

    modport source (output valid, output action, output char_code, input ready);
    modport sink   (input valid, input action, input char_code, output ready);
endinterface

// ----- hw/rtl/qlt_out_if.sv -----
// Output channel carrying one tokenizer result.
interface qlt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, output kind, output out_char, output last, input ready);
    modport sink   (input valid, input kind, input out_char, input last, output ready);
endinterface

// ----- hw/rtl/qlt_step.sv -----
// Input register, scanner state and combinational decode of one request.
module qlt_step
(
    input  logic                clk,
    input  logic                rst_n,
    qlt_in_if.sink              in_chan,
    input  logic                space_ok,
    output qlt_pkg::push_t      push
);

    logic       in_full_reg, in_full_next;
    logic       act_reg;
    logic [7:0] char_reg;

    logic [1:0] mode_reg, mode_next;
    logic [1:0] quote_reg, quote_next;
    logic       bs_reg, bs_next;
    logic       ne_reg, ne_next;

    logic consume;
    logic accept;

    qlt_pkg::result_t [2:0] res;
    logic [1:0]             n;

    assign consume       = in_full_reg && space_ok;
    assign in_chan.ready = !in_full_reg || consume;
    assign accept        = in_chan.valid && in_chan.ready;

    always_comb
    begin
        logic       do_tb;
        logic       done;
        logic       closer_match;
        logic [7:0] c;

        c          = char_reg;
        res        = '0;
        n          = 2'd0;
        mode_next  = mode_reg;
        quote_next = quote_reg;
        bs_next    = bs_reg;
        ne_next    = ne_reg;
        do_tb      = 1'b0;
        done       = 1'b0;
        closer_match = 1'b0;

        if (act_reg == qlt_pkg::ACTION_EOL)
        begin
            if (mode_reg == qlt_pkg::MODE_TOKEN)
            begin
                if (bs_reg)
                begin
                    res[n] = '{kind: qlt_pkg::KIND_CHAR, out_char: qlt_pkg::CH_BSLASH,
                               last: 1'b0};
                    n = n + 2'd1;
                end
                if (bs_reg || ne_reg)
                begin
                    res[n] = '{kind: qlt_pkg::KIND_TOKEN_END, out_char: 8'd0, last: 1'b0};
                    n = n + 2'd1;
                end
            end
            mode_next  = qlt_pkg::MODE_SKIP;
            quote_next = qlt_pkg::Q_NONE;
            bs_next    = 1'b0;
            ne_next    = 1'b0;
            res[n] = '{kind: qlt_pkg::KIND_LINE_END, out_char: 8'd0, last: 1'b0};
            n = n + 2'd1;
        end
        else
        begin
            case (mode_reg)
                qlt_pkg::MODE_SKIP:
                begin
                    if (qlt_pkg::is_space(c))
                    begin
                        mode_next = qlt_pkg::MODE_SKIP;
                    end
                    else if (c == qlt_pkg::CH_HASH)
                    begin
                        mode_next = qlt_pkg::MODE_COMMENT;
                    end
                    else
                    begin
                        mode_next = qlt_pkg::MODE_TOKEN;
                        ne_next   = 1'b0;
                        bs_next   = 1'b0;
                        if (c == qlt_pkg::CH_DQUOTE)
                        begin
                            quote_next = qlt_pkg::Q_DOUBLE;
                        end
                        else if (c == qlt_pkg::CH_SQUOTE)
                        begin
                            quote_next = qlt_pkg::Q_SINGLE;
                        end
                        else
                        begin
                            quote_next = qlt_pkg::Q_NONE;
                            do_tb      = 1'b1;
                        end
                    end
                end
                qlt_pkg::MODE_TOKEN:
                begin
                    do_tb = 1'b1;
                end
                qlt_pkg::MODE_AFTER_QUOTE:
                begin
                    if (qlt_pkg::is_space(c))
                    begin
                        mode_next = qlt_pkg::MODE_SKIP;
                    end
                    else if (c == qlt_pkg::CH_HASH)
                    begin
                        mode_next = qlt_pkg::MODE_COMMENT;
                    end
                end
                default:
                begin
                    // comment: drop the byte
                    mode_next = mode_reg;
                end
            endcase

            if (do_tb)
            begin
                closer_match = ((quote_next == qlt_pkg::Q_DOUBLE) && (c == qlt_pkg::CH_DQUOTE)) ||
                               ((quote_next == qlt_pkg::Q_SINGLE) && (c == qlt_pkg::CH_SQUOTE));
                if (bs_next)
                begin
                    bs_next = 1'b0;
                    ne_next = 1'b1;
                    if (qlt_pkg::is_escapable(c))
                    begin
                        res[n] = '{kind: qlt_pkg::KIND_CHAR, out_char: c, last: 1'b0};
                        n = n + 2'd1;
                        done = 1'b1;
                    end
                    else
                    begin
                        res[n] = '{kind: qlt_pkg::KIND_CHAR, out_char: qlt_pkg::CH_BSLASH,
                                   last: 1'b0};
                        n = n + 2'd1;
                    end
                end
                if (!done)
                begin
                    if (closer_match ||
                        ((quote_next == qlt_pkg::Q_NONE) &&
                         (qlt_pkg::is_space(c) || (c == qlt_pkg::CH_HASH))))
                    begin
                        if (ne_next)
                        begin
                            res[n] = '{kind: qlt_pkg::KIND_TOKEN_END, out_char: 8'd0,
                                       last: 1'b0};
                            n = n + 2'd1;
                        end
                        ne_next    = 1'b0;
                        bs_next    = 1'b0;
                        quote_next = qlt_pkg::Q_NONE;
                        if (closer_match)
                        begin
                            mode_next = qlt_pkg::MODE_AFTER_QUOTE;
                        end
                        else if (qlt_pkg::is_space(c))
                        begin
                            mode_next = qlt_pkg::MODE_SKIP;
                        end
                        else
                        begin
                            mode_next = qlt_pkg::MODE_COMMENT;
                        end
                    end
                    else if (c == qlt_pkg::CH_BSLASH)
                    begin
                        bs_next = 1'b1;
                    end
                    else
                    begin
                        res[n] = '{kind: qlt_pkg::KIND_CHAR, out_char: c, last: 1'b0};
                        n = n + 2'd1;
                        ne_next = 1'b1;
                    end
                end
            end
        end

        if (n != 2'd0)
        begin
            res[n - 2'd1].last = 1'b1;
        end
    end

    assign push.num  = consume ? n : 2'd0;
    assign push.item = res;

    assign in_full_next = accept ? 1'b1 : (consume ? 1'b0 : in_full_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            mode_reg    <= qlt_pkg::MODE_SKIP;
            quote_reg   <= qlt_pkg::Q_NONE;
            bs_reg      <= 1'b0;
            ne_reg      <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            if (consume)
            begin
                mode_reg  <= mode_next;
                quote_reg <= quote_next;
                bs_reg    <= bs_next;
                ne_reg    <= ne_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= in_chan.action;
            char_reg <= in_chan.char_code;
        end
    end

endmodule

// ----- hw/rtl/qlt_fifo.sv -----
// Result queue taking up to three results per cycle and giving one per cycle while the receiver is ready.
module qlt_fifo
#(
    parameter int unsigned DEPTH = qlt_pkg::FifoDepth
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  qlt_pkg::push_t push,
    output logic           space_ok,
    qlt_out_if.source      out_chan
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [1:0] k);
        logic [PTR_W+1:0] s;
        s = {2'b00, p} + {{PTR_W{1'b0}}, k};
        if (s >= (PTR_W+2)'(DEPTH))
        begin
            s = s - (PTR_W+2)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    qlt_pkg::result_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign space_ok       = count_reg <= CNT_W'(DEPTH - qlt_pkg::MaxPush);
    assign out_chan.valid = count_reg != '0;
    assign pop            = out_chan.valid && out_chan.ready;

    assign out_chan.kind     = mem[rd_ptr_reg].kind;
    assign out_chan.out_char = mem[rd_ptr_reg].out_char;
    assign out_chan.last     = mem[rd_ptr_reg].last;

    assign wr_ptr_next = ptr_add(wr_ptr_reg, push.num);
    assign rd_ptr_next = pop ? ptr_add(rd_ptr_reg, 2'd1) : rd_ptr_reg;
    assign count_next  = count_reg + CNT_W'(push.num) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < push.num)
            begin
                mem[ptr_add(wr_ptr_reg, 2'(i))] <= push.item[i];
            end
        end
    end

endmodule

// ----- hw/rtl/quoted_line_tokenizer_top.sv -----
// Quoted line tokenizer: top level joining the decode stage and the result queue.
//
// in_chan takes one request per line byte (action 0, byte in char_code) and
// one end-of-line request (action 1) after the last byte of each line.
// out_chan gives the results one per transfer: a token byte, a token-ended
// mark or a line-ended mark; last is set on the final result of a request.
// A request may cause zero to three results.
// A request is held in the input register and its results in the result queue,
// from which out_chan reads; a result leaves later when the queue lacks room
// or earlier results are still queued.
// Throughput: one request per cycle while each request causes at most one
// result and out_chan.ready stays high; the single output port sets the pace when a request causes more.
// The decode stage holds a request until the result queue has room for
// three entries, so a stalled receiver fills the queue and then stops
// in_chan; nothing is dropped.
// Reset clears the queue and returns the scanner to skipping whitespace
// outside any token; it accepts requests as soon as reset is released.
module quoted_line_tokenizer_top
#(
    parameter int unsigned FIFO_DEPTH = qlt_pkg::FifoDepth
)
(
    input  logic      clk,
    input  logic      rst_n,
    qlt_in_if.sink    in_chan,
    qlt_out_if.source out_chan
);

    qlt_pkg::push_t push;
    logic           space_ok;

    qlt_step u_step
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .space_ok (space_ok),
        .push     (push)
    );

    qlt_fifo
    #(
        .DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space_ok (space_ok),
        .out_chan (out_chan)
    );

endmodule

// ----- tb/sv/qlt_checker.sv -----
// Tokenizer checker: predicts results from accepted requests and compares them on the output.
module qlt_checker
(
    input  logic clk,
    input  logic rst_n,
    qlt_in_if    in_mon,
    qlt_out_if   out_mon,
    output int   fail_count,
    output int   pending,
    output int   reqs_seen,
    output int   results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import qlt_pkg::*;

    logic [1:0] scan_state;
    logic [1:0] quote_sel;
    logic       esc_wait;
    logic       tok_has_bytes;

    result_t step_results[$];
    result_t expected_results[$];

    function automatic logic blank_byte(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic escape_target(input logic [7:0] c);
        return blank_byte(c) || c == CH_DQUOTE || c == CH_SQUOTE ||
               c == CH_BSLASH || c == CH_HASH;
    endfunction

    function automatic void emit(input logic [1:0] kind, input logic [7:0] ch);
        result_t r;
        r.kind       = kind;
        r.out_char   = ch;
        r.last       = 1'b0;
        step_results = {step_results, r};
    endfunction

    // Mark the end only if the token produced something, then leave the token
    function automatic void close_token();
        if (tok_has_bytes)
            emit(KIND_TOKEN_END, 8'h00);
        tok_has_bytes = 1'b0;
        esc_wait      = 1'b0;
        quote_sel     = Q_NONE;
    endfunction

    function automatic void take_token_byte(input logic [7:0] c);
        logic closes;
        closes = (quote_sel == Q_DOUBLE && c == CH_DQUOTE) ||
                 (quote_sel == Q_SINGLE && c == CH_SQUOTE);
        if (esc_wait)
        begin
            esc_wait      = 1'b0;
            tok_has_bytes = 1'b1;
            if (escape_target(c))
            begin
                emit(KIND_CHAR, c);
                return;
            end
            // not an escape: the backslash stands, then handle the byte as usual
            emit(KIND_CHAR, CH_BSLASH);
        end
        if (closes)
        begin
            close_token();
            scan_state = MODE_AFTER_QUOTE;
        end
        else if (quote_sel == Q_NONE && (blank_byte(c) || c == CH_HASH))
        begin
            close_token();
            scan_state = blank_byte(c) ? MODE_SKIP : MODE_COMMENT;
        end
        else if (c == CH_BSLASH)
        begin
            esc_wait = 1'b1;
        end
        else
        begin
            emit(KIND_CHAR, c);
            tok_has_bytes = 1'b1;
        end
    endfunction

    function automatic void tokenize(input logic action, input logic [7:0] c);
        result_t r;
        step_results.delete();
        if (action == ACTION_EOL)
        begin
            if (scan_state == MODE_TOKEN)
            begin
                if (esc_wait)
                begin
                    emit(KIND_CHAR, CH_BSLASH);
                    tok_has_bytes = 1'b1;
                end
                close_token();
            end
            scan_state    = MODE_SKIP;
            quote_sel     = Q_NONE;
            esc_wait      = 1'b0;
            tok_has_bytes = 1'b0;
            emit(KIND_LINE_END, 8'h00);
        end
        else
        begin
            case (scan_state)
                MODE_SKIP:
                begin
                    if (c == CH_HASH)
                        scan_state = MODE_COMMENT;
                    else if (!blank_byte(c))
                    begin
                        scan_state    = MODE_TOKEN;
                        tok_has_bytes = 1'b0;
                        esc_wait      = 1'b0;
                        if (c == CH_DQUOTE)
                            quote_sel = Q_DOUBLE;
                        else if (c == CH_SQUOTE)
                            quote_sel = Q_SINGLE;
                        else
                        begin
                            quote_sel = Q_NONE;
                            take_token_byte(c);
                        end
                    end
                end
                MODE_TOKEN:
                begin
                    take_token_byte(c);
                end
                MODE_AFTER_QUOTE:
                begin
                    if (blank_byte(c))
                        scan_state = MODE_SKIP;
                    else if (c == CH_HASH)
                        scan_state = MODE_COMMENT;
                end
                default:
                begin
                end
            endcase
        end
        if (step_results.size() > 0)
        begin
            r            = step_results.pop_back();
            r.last       = 1'b1;
            step_results = {step_results, r};
        end
        foreach (step_results[i])
            expected_results = {expected_results, step_results[i]};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            scan_state    = MODE_SKIP;
            quote_sel     = Q_NONE;
            esc_wait      = 1'b0;
            tok_has_bytes = 1'b0;
            expected_results.delete();
            fail_count      = 0;
            reqs_seen       = 0;
            results_checked = 0;
            pending         = 0;
        end
        else
        begin
            // predict first: a result can never leave in the cycle its request enters
            if (in_mon.valid && in_mon.ready)
            begin
                tokenize(in_mon.action, in_mon.char_code);
                reqs_seen++;
            end
            if (out_mon.valid && out_mon.ready)
            begin
                got.kind     = out_mon.kind;
                got.out_char = out_mon.out_char;
                got.last     = out_mon.last;
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t ERROR unexpected result: expected none, %s",
                             $time, "got the following");
                    $display("%0t   kind=%0d char=%02h last=%0b",
                             $time, got.kind, got.out_char, got.last);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind)
                    begin
                        $display("%0t ERROR kind: expected %0d, got %0d",
                                 $time, want.kind, got.kind);
                        fail_count++;
                    end
                    if (got.out_char !== want.out_char)
                    begin
                        $display("%0t ERROR out_char: expected %02h, got %02h",
                                 $time, want.out_char, got.out_char);
                        fail_count++;
                    end
                    if (got.last !== want.last)
                    begin
                        $display("%0t ERROR last: expected %0b, got %0b",
                                 $time, want.last, got.last);
                        fail_count++;
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top: clock, reset, line stimulus, receiver pacing and the final verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qlt_pkg::*;

    localparam int RandomTarget = 90;
    localparam int HoldCycles   = 100;

    logic clk;
    logic rst_n;

    qlt_in_if  in_chan();
    qlt_out_if out_chan();

    int fail_count;
    int pending;
    int reqs_seen;
    int results_checked;

    int sent_reqs;
    int random_reqs;
    int line_count;

    logic src_idle_en;
    logic sink_idle_en;
    logic sink_hold;
    logic hold_req;

    logic [7:0] line_bytes[$];

    // bit 8 is the action, bits 7:0 the byte
    logic [8:0] directed_reqs [26] = '{
        {ACTION_CHAR, 8'h61}, {ACTION_CHAR, CH_HASH}, {ACTION_CHAR, 8'h78},
        {ACTION_EOL, 8'h00},
        {ACTION_CHAR, CH_DQUOTE}, {ACTION_CHAR, CH_DQUOTE}, {ACTION_CHAR, CH_SPACE},
        {ACTION_CHAR, CH_SQUOTE}, {ACTION_CHAR, 8'h71}, {ACTION_CHAR, CH_SQUOTE},
        {ACTION_CHAR, 8'h7A}, {ACTION_CHAR, CH_HASH}, {ACTION_EOL, 8'hFF},
        {ACTION_CHAR, 8'h00}, {ACTION_CHAR, 8'hFF}, {ACTION_CHAR, CH_BSLASH},
        {ACTION_CHAR, CH_HASH}, {ACTION_CHAR, CH_BSLASH}, {ACTION_CHAR, 8'h78},
        {ACTION_CHAR, CH_TAB}, {ACTION_CHAR, CH_BSLASH}, {ACTION_EOL, 8'h5A},
        {ACTION_CHAR, CH_DQUOTE}, {ACTION_CHAR, CH_HASH}, {ACTION_CHAR, CH_CR},
        {ACTION_EOL, 8'h00}
    };

    quoted_line_tokenizer_top u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    qlt_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_mon          (in_chan),
        .out_mon         (out_chan),
        .fail_count      (fail_count),
        .pending         (pending),
        .reqs_seen       (reqs_seen),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n              = 1'b0;
        in_chan.valid      = 1'b0;
        in_chan.action     = ACTION_CHAR;
        in_chan.char_code  = 8'h00;
        out_chan.ready     = 1'b0;
        src_idle_en        = 1'b1;
        sink_idle_en       = 1'b1;
        sink_hold          = 1'b0;
        hold_req           = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Receiver pacing
    always @(posedge clk)
    begin
        if (sink_hold)
            out_chan.ready <= 1'b0;
        else if (sink_idle_en && $urandom_range(99) < 38)
            out_chan.ready <= 1'b0;
        else
            out_chan.ready <= 1'b1;
    end

    // Long receiver hold-off, counted here while the sender keeps offering
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        sink_hold <= 1'b0;
    end

    initial
    begin
        #500_000;
        $display("** quoted_line_tokenizer_top: FAILED **");
        $finish;
    end

    task automatic send_req(input logic act, input logic [7:0] ch);
        while (src_idle_en && $urandom_range(99) < 38)
        begin
            in_chan.valid <= 1'b0;
            @(posedge clk);
        end
        in_chan.valid     <= 1'b1;
        in_chan.action    <= act;
        in_chan.char_code <= ch;
        do
            @(posedge clk);
        while (!in_chan.ready);
        sent_reqs++;
    endtask

    task automatic wait_drained();
        wait (reqs_seen == sent_reqs && pending == 0);
    endtask

    function automatic logic [7:0] blank_pick();
        int v;
        v = $urandom_range(0, 5);
        return (v == 5) ? CH_SPACE : 8'(CH_TAB + v);
    endfunction

    function automatic logic [7:0] word_pick();
        case ($urandom_range(0, 11))
            0:       return CH_BSLASH;
            1:       return 8'(8'h80 + $urandom_range(0, 127));
            2:       return 8'($urandom_range(0, 255));
            default: return 8'(8'h61 + $urandom_range(0, 25));
        endcase
    endfunction

    // Build one line from words, quoted tokens, comments and noise
    task automatic build_line();
        int n_tok;
        int sel;
        int len;
        logic [7:0] q;
        line_bytes.delete();
        n_tok = $urandom_range(0, 3);
        for (int t = 0; t < n_tok; t++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 4)
            begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    line_bytes = {line_bytes, word_pick()};
                if ($urandom_range(0, 3) == 0)
                begin
                    line_bytes = {line_bytes, CH_BSLASH};
                    case ($urandom_range(0, 3))
                        0:       line_bytes = {line_bytes, blank_pick()};
                        1:       line_bytes = {line_bytes, CH_HASH};
                        2:       line_bytes = {line_bytes, CH_DQUOTE};
                        default: line_bytes = {line_bytes, CH_SQUOTE};
                    endcase
                end
            end
            else if (sel < 7)
            begin
                q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                line_bytes = {line_bytes, q};
                len = $urandom_range(0, 4);
                for (int i = 0; i < len; i++)
                begin
                    case ($urandom_range(0, 5))
                        0:       line_bytes = {line_bytes, blank_pick()};
                        1:       line_bytes = {line_bytes, CH_HASH};
                        2:       line_bytes = {line_bytes,
                                               (q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE};
                        default: line_bytes = {line_bytes, word_pick()};
                    endcase
                end
                // leave some quotes open to the end of the line
                if ($urandom_range(0, 4) != 0)
                    line_bytes = {line_bytes, q};
                len = $urandom_range(0, 2);
                for (int i = 0; i < len; i++)
                    line_bytes = {line_bytes, word_pick()};
            end
            else if (sel < 8)
            begin
                line_bytes = {line_bytes, CH_HASH};
                len = $urandom_range(0, 3);
                for (int i = 0; i < len; i++)
                    line_bytes = {line_bytes, 8'($urandom_range(0, 255))};
            end
            else
            begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    line_bytes = {line_bytes, 8'($urandom_range(0, 255))};
            end
            len = $urandom_range(0, 2);
            for (int i = 0; i < len; i++)
                line_bytes = {line_bytes, blank_pick()};
        end
    endtask

    initial
    begin
        sent_reqs   = 0;
        random_reqs = 0;
        line_count  = 0;
        wait (rst_n);
        @(posedge clk);

        foreach (directed_reqs[i])
        begin
            send_req(directed_reqs[i][8], directed_reqs[i][7:0]);
            if (directed_reqs[i][8] == ACTION_EOL)
                line_count++;
        end

        // hold the sender until the directed lines have fully drained
        in_chan.valid <= 1'b0;
        wait_drained();
        @(posedge clk);

        while (random_reqs < RandomTarget)
        begin
            build_line();
            foreach (line_bytes[i])
            begin
                src_idle_en  <= !(random_reqs >= 50 && random_reqs < 85);
                sink_idle_en <= !(random_reqs >= 50 && random_reqs < 85);
                if (random_reqs >= 15)
                    hold_req <= 1'b1;
                send_req(ACTION_CHAR, line_bytes[i]);
                random_reqs++;
            end
            send_req(ACTION_EOL, 8'($urandom_range(0, 255)));
            random_reqs++;
            line_count++;
        end
        in_chan.valid <= 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);

        $display("Run covered %0d requests over %0d lines (%0d random),",
                 sent_reqs, line_count, random_reqs);
        $display("%0d results compared, with quotes, escapes, comments and a %0d-cycle hold-off.",
                 results_checked, HoldCycles);
        if (fail_count == 0)
            $display("** quoted_line_tokenizer_top: PASSED **");
        else
            $display("** quoted_line_tokenizer_top: FAILED **");
        $finish;
    end

endmodule
